FILE: src/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

    // Table geometry and field widths
    localparam int SKT_DEPTH = 256;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 24;
    localparam int POS_W     = 8;
    localparam int IDX_W     = 9;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;

    // Operation kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic srch_rd;
        logic srch_cmp;
        logic shift_rd;
        logic shift_wr;
        logic put;
        logic rd_issue;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [KIND_W-1:0] new_kind;
        logic [KIND_W-1:0] op_kind;
        logic              full;
        logic              in_range;
        logic              search_more;
        logic              shift_more;
        logic              slot_free;
    } stat_t;

endpackage

FILE: src/sorted_key_table_core.sv
`timescale 1ns / 1ps

// Sorted key table: up to DEPTH (key, payload) entries kept in ascending
// signed key order in a single-port-write, registered-read RAM.
// Input channel (in_valid/in_stall) takes one operation per transaction:
// insert, find (lower bound), read by position, or clear. Output channel
// (out_valid/out_stall) returns exactly one result transaction per operation.
// Operations run one at a time; in_stall is high from acceptance until the
// result is loaded into the output register.
// After acceptance the operation steps through its states: a find does the binary
// search, an insert does the search, shifts the entries above the insertion index
// up and then writes the new entry, a read issues one RAM read, and a clear, a
// rejected insert or an out-of-range read goes straight to the result. The binary
// search takes at most $clog2(DEPTH+1) steps, each a RAM read and then a compare,
// and the shift moves one entry at a time, by a read and then a write, through the
// RAM's single ports.
// When out_stall holds the output register full, a finished result waits
// and the block takes no new transaction until the register frees.
// Reset empties the table (count zero); RAM contents are not cleared and
// entries at or above the count are never read. DEPTH ranges 2 to 256.

module sorted_key_table_core
    import skt_pkg::*;
#(
    parameter int DEPTH = SKT_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [KIND_W-1:0]        kind,
    input  logic signed [KEY_W-1:0]  key,
    input  logic [PAY_W-1:0]         payload,
    input  logic [POS_W-1:0]         position,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic [IDX_W-1:0]         index,
    output logic signed [KEY_W-1:0]  found_key,
    output logic [PAY_W-1:0]         found_payload,
    output logic [IDX_W-1:0]         count
);

    cmd_t  cmd;
    stat_t st;

    skt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    skt_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .kind          (kind),
        .key           (key),
        .payload       (payload),
        .position      (position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .index         (index),
        .found_key     (found_key),
        .found_payload (found_payload),
        .count         (count)
    );

endmodule

FILE: src/skt_ram.sv
`timescale 1ns / 1ps

module skt_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/skt_ctrl.sv
`timescale 1ns / 1ps

module skt_ctrl
    import skt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t st,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_SHRD = 3'd3;
    localparam logic [2:0] S_SHWR = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;
    localparam logic [2:0] S_RD   = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Take a new transaction only when idle
    assign in_stall = (state_reg != S_IDLE);

    // Sequence the operation
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (st.new_kind)
                        KIND_INSERT: state_next = st.full ? S_FIN : S_SRCH;
                        KIND_FIND:   state_next = S_SRCH;
                        KIND_READ:   state_next = st.in_range ? S_RD : S_FIN;
                        default:     state_next = S_FIN;
                    endcase
                end
            end
            S_SRCH:
            begin
                if (st.search_more)
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_CMP;
                end
                else if (st.op_kind == KIND_INSERT)
                begin
                    state_next = S_SHRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRCH;
            end
            S_SHRD:
            begin
                if (st.shift_more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHWR;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_SHWR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHRD;
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_FIN;
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (st.slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/skt_dp.sv
`timescale 1ns / 1ps

module skt_dp
    import skt_pkg::*;
#(
    parameter int DEPTH = SKT_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    st,
    input  logic [KIND_W-1:0]        kind,
    input  logic signed [KEY_W-1:0]  key,
    input  logic [PAY_W-1:0]         payload,
    input  logic [POS_W-1:0]         position,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic [IDX_W-1:0]         index,
    output logic signed [KEY_W-1:0]  found_key,
    output logic [PAY_W-1:0]         found_payload,
    output logic [IDX_W-1:0]         count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_W + PAY_W;

    // Control registers
    logic [KIND_W-1:0] kind_reg,   kind_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic [CW-1:0]     lo_reg,     lo_next;
    logic [CW-1:0]     hi_reg,     hi_next;
    logic [CW-1:0]     p_reg,      p_next;
    logic              out_valid_reg, out_valid_next;

    // Operand and result registers
    logic signed [KEY_W-1:0] key_reg;
    logic [PAY_W-1:0]        payload_reg;
    logic [POS_W-1:0]        position_reg;
    logic [CW-1:0]           mid_reg;
    logic [STAT_W-1:0]       status_o_reg;
    logic [IDX_W-1:0]        index_o_reg;
    logic signed [KEY_W-1:0] fkey_o_reg;
    logic [PAY_W-1:0]        fpay_o_reg;
    logic [IDX_W-1:0]        count_o_reg;

    // Entry memory
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [EW-1:0]           ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [EW-1:0]           ram_rdata;
    logic signed [KEY_W-1:0] rd_key;
    logic [PAY_W-1:0]        rd_pay;

    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid_w;
    logic [CW-1:0]           p_dec;
    logic                    full_w;
    logic                    in_range_w;
    logic                    slot_free_w;
    logic                    read_ok;
    logic [IDX_W-1:0]        index_w;

    skt_ram
    #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[EW-1:PAY_W];
    assign rd_pay = ram_rdata[PAY_W-1:0];

    // Search midpoint and shift pointer arithmetic
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_w   = mid_sum[CW:1];
    assign p_dec   = p_reg - CW'(1);

    assign full_w      = (count_reg == CW'(DEPTH));
    assign in_range_w  = (IDX_W'(position) < IDX_W'(count_reg));
    assign slot_free_w = !out_valid_reg || !out_stall;

    // Status to controller
    assign st.new_kind    = kind;
    assign st.op_kind     = kind_reg;
    assign st.full        = full_w;
    assign st.in_range    = in_range_w;
    assign st.search_more = (lo_reg < hi_reg);
    assign st.shift_more  = (p_reg > lo_reg);
    assign st.slot_free   = slot_free_w;

    // Memory port selection
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = mid_w[AW-1:0];
        if (cmd.shift_rd)
        begin
            ram_re    = 1'b1;
            ram_raddr = p_dec[AW-1:0];
        end
        else if (cmd.rd_issue)
        begin
            ram_re    = 1'b1;
            ram_raddr = position_reg[AW-1:0];
        end
        else if (cmd.srch_rd)
        begin
            ram_re = 1'b1;
        end
    end

    always_comb
    begin
        ram_we    = cmd.shift_wr || cmd.put;
        ram_waddr = cmd.put ? lo_reg[AW-1:0] : p_reg[AW-1:0];
        ram_wdata = cmd.put ? {key_reg, payload_reg} : ram_rdata;
    end

    // Result index by operation
    always_comb
    begin
        case (kind_reg)
            KIND_INSERT: index_w = (status_reg == ST_FULL) ? IDX_W'(count_reg)
                                                            : IDX_W'(lo_reg);
            KIND_FIND:   index_w = IDX_W'(lo_reg);
            KIND_READ:   index_w = IDX_W'(position_reg);
            default:     index_w = '0;
        endcase
    end

    assign read_ok = (kind_reg == KIND_READ) && (status_reg == ST_OK);

    // Next state of control registers
    always_comb
    begin
        kind_next      = kind_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        p_next         = p_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.capture)
        begin
            kind_next   = kind;
            lo_next     = '0;
            hi_next     = count_reg;
            p_next      = count_reg;
            status_next = ST_OK;
            if ((kind == KIND_INSERT) && full_w)
            begin
                status_next = ST_FULL;
            end
            if ((kind == KIND_READ) && !in_range_w)
            begin
                status_next = ST_RANGE;
            end
            if (kind == KIND_CLEAR)
            begin
                count_next = '0;
            end
        end
        if (cmd.srch_cmp)
        begin
            if (rd_key >= key_reg)
            begin
                hi_next = mid_reg;
            end
            else
            begin
                lo_next = mid_reg + CW'(1);
            end
        end
        if (cmd.shift_wr)
        begin
            p_next = p_dec;
        end
        if (cmd.put)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_INSERT;
            status_reg    <= ST_OK;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg      <= kind_next;
            status_reg    <= status_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            p_reg         <= p_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold operands and load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg      <= key;
            payload_reg  <= payload;
            position_reg <= position;
        end
        if (cmd.srch_rd)
        begin
            mid_reg <= mid_w;
        end
        if (cmd.load_out)
        begin
            status_o_reg <= status_reg;
            index_o_reg  <= index_w;
            fkey_o_reg   <= read_ok ? rd_key : '0;
            fpay_o_reg   <= read_ok ? rd_pay : '0;
            count_o_reg  <= IDX_W'(count_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_o_reg;
    assign index         = index_o_reg;
    assign found_key     = fkey_o_reg;
    assign found_payload = fpay_o_reg;
    assign count         = count_o_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above table depth");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search window inverted");

    a_put_increments: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not advance count");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture && (kind == KIND_CLEAR) |=> count_reg == '0)
        else $error("clear did not empty table");

    a_shift_above_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> p_reg > lo_reg)
        else $error("shift wrote at or below insertion slot");
`endif

endmodule

FILE: test/sorted_key_table_core_tb.sv
`timescale 1ns / 1ps

module sorted_key_table_core_tb
    import skt_pkg::*;
();

    localparam int HANG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 600;
    localparam int RANDOM_OPS   = 1700;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [IDX_W-1:0]        index;
        logic signed [KEY_W-1:0] found_key;
        logic [PAY_W-1:0]        found_payload;
        logic [IDX_W-1:0]        count;
    } table_result_t;

    // Shadow copy of the sorted table plus the queue of results still owed
    class sorted_table_tracker;
        logic signed [KEY_W-1:0] keys [SKT_DEPTH];
        logic [PAY_W-1:0]        pays [SKT_DEPTH];
        int                      entries;
        table_result_t           owed_results[$];
        int                      mismatches;

        function new();
            entries    = 0;
            mismatches = 0;
        endfunction

        // First slot whose key is not below k, else the entry count
        function int first_not_below(logic signed [KEY_W-1:0] k);
            for (int i = 0; i < entries; i++)
            begin
                if (keys[i] >= k)
                    return i;
            end
            return entries;
        endfunction

        // Apply one accepted operation to the shadow table and queue its result
        function void note_op(logic [KIND_W-1:0] op, logic signed [KEY_W-1:0] k,
                              logic [PAY_W-1:0] p, logic [POS_W-1:0] pos);
            table_result_t r;
            int            slot;
            r = '0;
            r.status = ST_OK;
            case (op)
                KIND_INSERT:
                begin
                    if (entries >= SKT_DEPTH)
                    begin
                        r.status = ST_FULL;
                        r.index  = IDX_W'(entries);
                    end
                    else
                    begin
                        slot = first_not_below(k);
                        for (int j = entries; j > slot; j--)
                        begin
                            keys[j] = keys[j-1];
                            pays[j] = pays[j-1];
                        end
                        keys[slot] = k;
                        pays[slot] = p;
                        entries++;
                        r.index = IDX_W'(slot);
                    end
                end
                KIND_FIND:
                    r.index = IDX_W'(first_not_below(k));
                KIND_READ:
                begin
                    r.index = IDX_W'(pos);
                    if (int'(pos) < entries)
                    begin
                        r.found_key     = keys[pos];
                        r.found_payload = pays[pos];
                    end
                    else
                        r.status = ST_RANGE;
                end
                KIND_CLEAR:
                begin
                    entries = 0;
                    r.index = '0;
                end
            endcase
            r.count = IDX_W'(entries);
            owed_results.push_back(r);
        endfunction

        // Compare one result transaction against the oldest owed result
        function void check_result(table_result_t got);
            table_result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result with no operation outstanding: status %0d index %0d",
                       got.status, got.index);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.index !== want.index)
            begin
                $error("index: expected %0d, actual %0d", want.index, got.index);
                mismatches++;
            end
            if (got.found_key !== want.found_key)
            begin
                $error("found_key: expected %0d, actual %0d", want.found_key, got.found_key);
                mismatches++;
            end
            if (got.found_payload !== want.found_payload)
            begin
                $error("found_payload: expected 0x%06h, actual 0x%06h",
                       want.found_payload, got.found_payload);
                mismatches++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, got.count);
                mismatches++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [KIND_W-1:0]       kind      = KIND_FIND;
    logic signed [KEY_W-1:0] key       = '0;
    logic [PAY_W-1:0]        payload   = '0;
    logic [POS_W-1:0]        position  = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STAT_W-1:0]       status;
    logic [IDX_W-1:0]        index;
    logic signed [KEY_W-1:0] found_key;
    logic [PAY_W-1:0]        found_payload;
    logic [IDX_W-1:0]        count;

    sorted_table_tracker tracker;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  quiet_cycles   = 0;
    int                  ops_sent       = 0;

    sorted_key_table_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .key           (key),
        .payload       (payload),
        .position      (position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .index         (index),
        .found_key     (found_key),
        .found_payload (found_payload),
        .count         (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        out_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(table_result_t'{status, index, found_key,
                                                 found_payload, count});
    end

    // End the run if no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one operation, idling first at random, and hold it until accepted
    task automatic send_op(input logic [KIND_W-1:0] op, input logic signed [KEY_W-1:0] k,
                           input logic [PAY_W-1:0] p, input logic [POS_W-1:0] pos);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        key      <= k;
        payload  <= p;
        position <= pos;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_op(op, k, p, pos);
        ops_sent++;
    endtask

    // Mix of extremes, a narrow band that forces equal keys, keys already in the table, and full-range keys
    function automatic logic signed [KEY_W-1:0] draw_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            case ($urandom_range(0, 3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end
        else if (roll < 40)
            return KEY_W'(int'($urandom_range(0, 16)) - 8);
        else if (roll < 55 && tracker.entries > 0)
            return tracker.keys[$urandom_range(0, tracker.entries - 1)];
        return $urandom;
    endfunction

    // Send one operation of the given kind with random fields
    task automatic send_random(input logic [KIND_W-1:0] op);
        logic [POS_W-1:0] pos;
        if (tracker.entries > 0 && $urandom_range(0, 99) < 75)
            pos = POS_W'($urandom_range(0, tracker.entries - 1));
        else
            pos = POS_W'($urandom_range(0, 255));
        send_op(op, draw_key(), PAY_W'($urandom), pos);
    endtask

    // Fill the table to the top, poke at it while full, then empty it
    task automatic fill_table();
        send_random(KIND_CLEAR);
        while (tracker.entries < SKT_DEPTH)
        begin
            case ($urandom_range(0, 9))
                0:       send_random(KIND_FIND);
                1:       send_random(KIND_READ);
                default: send_random(KIND_INSERT);
            endcase
        end
        repeat (4) send_random(KIND_INSERT);
        repeat (4) send_random(KIND_READ);
        repeat (2) send_random(KIND_FIND);
        send_random(KIND_CLEAR);
    endtask

    // Random operations, biased toward inserts so the table builds up
    task automatic run_random(input int ops, input bit with_fill);
        int          stop_at;
        int unsigned roll;
        stop_at = ops_sent + ops;
        if (with_fill)
            fill_table();
        while (ops_sent < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                send_random(KIND_CLEAR);
            else if (roll < 50)
                send_random(KIND_INSERT);
            else if (roll < 70)
                send_random(KIND_FIND);
            else
                send_random(KIND_READ);
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extreme keys and payloads, equal keys, range edges
        send_op(KIND_CLEAR, '0, '0, '0);
        send_op(KIND_READ, '0, '0, 8'd0);
        send_op(KIND_FIND, '0, '0, '0);
        send_op(KIND_INSERT, KEY_MAX, 24'hFF_FFFF, '0);
        send_op(KIND_INSERT, KEY_MIN, 24'h00_0000, '0);
        send_op(KIND_INSERT, 32'sd0, 24'h12_3456, '0);
        send_op(KIND_INSERT, 32'sd0, 24'hAB_CDEF, '0);
        send_op(KIND_INSERT, -32'sd1, 24'h55_AA55, '0);
        send_op(KIND_INSERT, KEY_MAX, 24'h0F_0F0F, '0);
        send_op(KIND_FIND, KEY_MIN, '0, '0);
        send_op(KIND_FIND, KEY_MAX, '0, '0);
        send_op(KIND_FIND, 32'sd1, '0, '0);
        send_op(KIND_FIND, -32'sd2, '0, '0);
        for (int i = 0; i <= 6; i++)
            send_op(KIND_READ, '0, '0, POS_W'(i));
        send_op(KIND_READ, '0, '0, 8'd255);
        send_op(KIND_CLEAR, KEY_MAX, 24'hFF_FFFF, 8'hFF);
        send_op(KIND_READ, '0, '0, 8'd0);
        send_op(KIND_FIND, KEY_MAX, '0, '0);
        send_op(KIND_INSERT, 32'sd1, 24'h00_0001, '0);

        // Random phases: no idling, sender idle, receiver stalling, both
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_OPS / 4, 1'b1);
        send_idle_pct  = 51;
        recv_stall_pct = 0;
        run_random(RANDOM_OPS / 4, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 51;
        run_random(RANDOM_OPS / 4, 1'b0);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        run_random(RANDOM_OPS / 4, 1'b1);

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain owed results, then watch for stray ones
        while (tracker.owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
